/* rtl/core/jtok_pkg.sv */
package jtok_pkg;

  localparam int unsigned MANT_OUT_W = 60;
  localparam int unsigned EXP_W      = 12;

  // character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_E_LO   = 8'h65;
  localparam logic [7:0] CH_E_UP   = 8'h45;

  typedef enum logic [3:0] {
    K_PUNCT    = 4'd0,
    K_TRUE     = 4'd1,
    K_FALSE    = 4'd2,
    K_NULL     = 4'd3,
    K_STR_BYTE = 4'd4,
    K_STR_END  = 4'd5,
    K_NUMBER   = 4'd6,
    K_ERROR    = 4'd7,
    K_END      = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    E_UNEXPECTED = 3'd0,
    E_END_ESCAPE = 3'd1,
    E_NO_QUOTE   = 3'd2,
    E_KEYWORD    = 3'd3,
    E_DIGIT      = 3'd4
  } err_t;

  typedef enum logic [3:0] {
    M_IDLE, M_STR, M_ESC, M_KW, M_NSIGN, M_NINT, M_NDOT, M_NFRAC,
    M_NE, M_NESIGN, M_NEXP, M_ERROR
  } mode_t;

  typedef struct packed {
    logic       action;
    logic [7:0] text_byte;
  } in_word_t;

  typedef struct packed {
    kind_t                   kind;
    logic [7:0]              char_value;
    logic                    negative;
    logic [MANT_OUT_W-1:0]   mantissa;
    logic signed [EXP_W-1:0] exponent;
    logic                    inexact;
    err_t                    error_code;
    logic                    last;
  } out_word_t;

endpackage

/* rtl/core/json_tokenizer.sv */
// json_tokenizer: streaming JSON lexer, one text byte per word.
// An input word's first result is registered and presented the cycle after the word is accepted.
// Throughput: 1 input word per cycle while each word yields at most one result and
// out_stall is low; a two-result word holds the input until its first result drains
// (one slot drains per unstalled cycle). Set by the 2-entry output buffer and single read port.
// Reset: rst_n low (synchronous) clears mode, keyword/number state and the buffer.
module json_tokenizer
  import jtok_pkg::*;
#(
  parameter int unsigned KEYWORD_LEN   = 7,
  parameter int unsigned MANTISSA_BITS = 60
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  // Mantissa register never needs more than 60 bits: the decimal cap fits.
  localparam int unsigned MANT_W = (MANTISSA_BITS < MANT_OUT_W) ? MANTISSA_BITS : MANT_OUT_W;
  localparam int unsigned IDX_W  = $clog2(KEYWORD_LEN);
  localparam int unsigned CNT_W  = $clog2(KEYWORD_LEN + 1);

  // Saturation limit: min(2^MANTISSA_BITS-1, 10^18-1).
  localparam logic [63:0] LIM = (MANTISSA_BITS >= 60) ? 64'd999999999999999999
                                                      : ((64'd1 << MANTISSA_BITS) - 64'd1);

  localparam logic signed [EXP_W-1:0] FRAC_MAX = 12'sd2047;
  localparam logic signed [EXP_W-1:0] FRAC_MIN = -12'sd2048;

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  mode_t                   mode_r,    mode_nxt;
  logic [7:0]              kw_bytes_r [KEYWORD_LEN];
  logic [7:0]              kw_bytes_nxt [KEYWORD_LEN];
  logic [CNT_W-1:0]        kw_cnt_r,  kw_cnt_nxt;
  logic [MANT_W-1:0]       mant_r,    mant_nxt;
  logic signed [EXP_W-1:0] frac_r,    frac_nxt;   // dropped int digits minus kept fraction digits
  logic [EXP_W-1:0]        expv_r,    expv_nxt;   // written exponent magnitude
  logic                    exp_neg_r, exp_neg_nxt;
  logic                    num_neg_r, num_neg_nxt;
  logic                    sat_r,     sat_nxt;

  // Output buffer: q0 is the head, q1 the second result of the same word.
  out_word_t  q0_r, q0_nxt;
  out_word_t  q1_r, q1_nxt;
  logic [1:0] qcnt_r, qcnt_nxt;

  // ---------------------------------------------------------------------
  // Handshake. An input word is taken only when the buffer will be empty,
  // so both of its results always fit.
  // ---------------------------------------------------------------------
  logic pop, step;

  assign out_valid = (qcnt_r != 2'd0);
  assign out_word  = q0_r;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = !((qcnt_r == 2'd0) || ((qcnt_r == 2'd1) && pop));
  assign step      = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Byte decode and arithmetic units
  // ---------------------------------------------------------------------
  logic [7:0] c;
  logic       eoi;
  logic       is_sp, is_dg, is_al, is_pu, is_e;
  logic [3:0] d;

  logic       kw_append, kw_close, kw_ok;
  logic       num_close, num_fail, start_go;
  out_word_t  kw_word, num_word;

  logic                    md_fresh, md_frac, md_fits;
  logic [MANT_W-1:0]       md_base;
  logic [63:0]             md_base64, md_prod;
  logic [MANT_W-1:0]       md_m;
  logic signed [EXP_W-1:0] md_base_fd, md_fd;
  logic                    md_sat;

  logic [15:0]      ed_prod;
  logic [EXP_W-1:0] ed_v;
  logic             ed_ovf;

  logic signed [13:0] ne_full;
  logic signed [EXP_W-1:0] ne_exp;
  logic               ne_clamp;

  function automatic out_word_t mk_word(kind_t k, logic [7:0] ch, err_t e);
    out_word_t w;
    w            = '0;
    w.kind       = k;
    w.char_value = ch;
    w.error_code = e;
    return w;
  endfunction

  always_comb begin
    c     = in_word.text_byte;
    eoi   = in_word.action;
    is_sp = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
            (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
    is_dg = (c >= 8'h30) && (c <= 8'h39);
    is_al = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    is_pu = (c == CH_COLON) || (c == CH_COMMA) || (c == CH_LBRACE) ||
            (c == CH_RBRACE) || (c == CH_LBRACK) || (c == CH_RBRACK);
    is_e  = (c == CH_E_LO) || (c == CH_E_UP);
    d     = is_dg ? c[3:0] : 4'd0;

    // keyword lookup
    kw_append = is_al && (kw_cnt_r < CNT_W'(KEYWORD_LEN));
    kw_close  = (mode_r == M_KW) && !kw_append;
    if ((kw_cnt_r == CNT_W'(4)) && (kw_bytes_r[0] == 8'h74) && (kw_bytes_r[1] == 8'h72) &&
        (kw_bytes_r[2] == 8'h75) && (kw_bytes_r[3] == 8'h65)) begin
      kw_word = mk_word(K_TRUE, 8'h00, E_UNEXPECTED);
      kw_ok   = 1'b1;
    end else if ((kw_cnt_r == CNT_W'(5)) && (kw_bytes_r[0] == 8'h66) &&
                 (kw_bytes_r[1] == 8'h61) && (kw_bytes_r[2] == 8'h6C) &&
                 (kw_bytes_r[3] == 8'h73) && (kw_bytes_r[4] == 8'h65)) begin
      kw_word = mk_word(K_FALSE, 8'h00, E_UNEXPECTED);
      kw_ok   = 1'b1;
    end else if ((kw_cnt_r == CNT_W'(4)) && (kw_bytes_r[0] == 8'h6E) &&
                 (kw_bytes_r[1] == 8'h75) && (kw_bytes_r[2] == 8'h6C) &&
                 (kw_bytes_r[3] == 8'h6C)) begin
      kw_word = mk_word(K_NULL, 8'h00, E_UNEXPECTED);
      kw_ok   = 1'b1;
    end else begin
      kw_word = mk_word(K_ERROR, 8'h00, E_KEYWORD);
      kw_ok   = 1'b0;
    end

    // number end / malformed number on a text byte
    num_close = ((mode_r == M_NINT) && !is_dg && (c != CH_DOT) && !is_e) ||
                ((mode_r == M_NFRAC) && !is_dg && !is_e) ||
                ((mode_r == M_NEXP) && !is_dg);
    num_fail  = (((mode_r == M_NSIGN) || (mode_r == M_NDOT) || (mode_r == M_NESIGN)) &&
                 !is_dg) ||
                ((mode_r == M_NE) && !is_dg && (c != CH_MINUS) && (c != CH_PLUS));

    // the byte starts a new token
    start_go = !eoi && ((mode_r == M_IDLE) || (kw_close && kw_ok) || num_close);

    // mantissa digit: a starting digit works on a cleared number
    md_fresh   = start_go;
    md_frac    = !md_fresh && ((mode_r == M_NDOT) || (mode_r == M_NFRAC));
    md_base    = md_fresh ? '0 : mant_r;
    md_base_fd = md_fresh ? '0 : frac_r;
    md_sat     = md_fresh ? 1'b0 : sat_r;
    md_base64  = 64'(md_base);
    // base is below 2^60, so base*10+9 cannot wrap 64 bits
    md_prod    = (md_base64 << 3) + (md_base64 << 1) + 64'(d);
    md_fits    = (md_prod <= LIM);
    md_m       = md_base;
    md_fd      = md_base_fd;
    if (md_fits) begin
      md_m = md_prod[MANT_W-1:0];
      if (md_frac) begin
        if (md_base_fd > FRAC_MIN) md_fd = md_base_fd - 12'sd1;
        else md_sat = 1'b1;
      end
    end else begin
      if (d != 4'd0) md_sat = 1'b1;
      if (!md_frac) begin
        if (md_base_fd < FRAC_MAX) md_fd = md_base_fd + 12'sd1;
        else md_sat = 1'b1;
      end
    end

    // exponent digit, saturating at 4095
    ed_prod = ({4'b0, expv_r} << 3) + ({4'b0, expv_r} << 1) + {12'b0, d};
    ed_ovf  = (ed_prod[15:12] != 4'd0);
    ed_v    = ed_ovf ? 12'hFFF : ed_prod[11:0];

    // finished number
    ne_full = (exp_neg_r ? -$signed({2'b00, expv_r}) : $signed({2'b00, expv_r})) +
              14'(frac_r);
    ne_clamp = 1'b0;
    if (ne_full > 14'sd2047) begin
      ne_exp   = FRAC_MAX;
      ne_clamp = 1'b1;
    end else if (ne_full < -14'sd2048) begin
      ne_exp   = FRAC_MIN;
      ne_clamp = 1'b1;
    end else begin
      ne_exp = ne_full[EXP_W-1:0];
    end
    num_word          = mk_word(K_NUMBER, 8'h00, E_UNEXPECTED);
    num_word.negative = num_neg_r;
    num_word.mantissa = MANT_OUT_W'(mant_r);
    num_word.exponent = ne_exp;
    num_word.inexact  = sat_r || ne_clamp;
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    mode_nxt     = mode_r;
    kw_bytes_nxt = kw_bytes_r;
    kw_cnt_nxt   = kw_cnt_r;
    mant_nxt     = mant_r;
    frac_nxt     = frac_r;
    expv_nxt     = expv_r;
    exp_neg_nxt  = exp_neg_r;
    num_neg_nxt  = num_neg_r;
    sat_nxt      = sat_r;
    if (step) begin
      if (eoi) begin
        mode_nxt    = M_IDLE;
        kw_cnt_nxt  = '0;
        mant_nxt    = '0;
        frac_nxt    = '0;
        expv_nxt    = '0;
        exp_neg_nxt = 1'b0;
        num_neg_nxt = 1'b0;
        sat_nxt     = 1'b0;
      end else begin
        case (mode_r)
          M_STR: begin
            if (c == CH_BSLASH) mode_nxt = M_ESC;
            else if (c == CH_QUOTE) mode_nxt = M_IDLE;
          end
          M_ESC: mode_nxt = M_STR;
          M_KW: begin
            if (kw_append) begin
              kw_bytes_nxt[kw_cnt_r[IDX_W-1:0]] = c;
              kw_cnt_nxt = kw_cnt_r + CNT_W'(1);
            end else begin
              kw_cnt_nxt = '0;
              mode_nxt   = kw_ok ? M_IDLE : M_ERROR;
            end
          end
          M_NSIGN, M_NDOT: begin
            if (is_dg) begin
              mant_nxt = md_m;
              frac_nxt = md_fd;
              sat_nxt  = md_sat;
              mode_nxt = (mode_r == M_NSIGN) ? M_NINT : M_NFRAC;
            end else begin
              mode_nxt = M_ERROR;
            end
          end
          M_NINT, M_NFRAC: begin
            if (is_dg) begin
              mant_nxt = md_m;
              frac_nxt = md_fd;
              sat_nxt  = md_sat;
            end else if ((mode_r == M_NINT) && (c == CH_DOT)) begin
              mode_nxt = M_NDOT;
            end else if (is_e) begin
              mode_nxt = M_NE;
            end
          end
          M_NE, M_NESIGN: begin
            if (is_dg) begin
              expv_nxt = ed_v;
              sat_nxt  = sat_r || ed_ovf;
              mode_nxt = M_NEXP;
            end else if ((mode_r == M_NE) && (c == CH_MINUS)) begin
              exp_neg_nxt = 1'b1;
              mode_nxt    = M_NESIGN;
            end else if ((mode_r == M_NE) && (c == CH_PLUS)) begin
              mode_nxt = M_NESIGN;
            end else begin
              mode_nxt = M_ERROR;
            end
          end
          M_NEXP: begin
            if (is_dg) begin
              expv_nxt = ed_v;
              sat_nxt  = sat_r || ed_ovf;
            end
          end
          default: ;
        endcase

        if (num_close) begin
          mode_nxt    = M_IDLE;
          mant_nxt    = '0;
          frac_nxt    = '0;
          expv_nxt    = '0;
          exp_neg_nxt = 1'b0;
          num_neg_nxt = 1'b0;
          sat_nxt     = 1'b0;
        end

        // new token on this byte
        if (start_go) begin
          if (c == CH_QUOTE) begin
            mode_nxt = M_STR;
          end else if (c == CH_MINUS) begin
            mant_nxt    = '0;
            frac_nxt    = '0;
            expv_nxt    = '0;
            exp_neg_nxt = 1'b0;
            num_neg_nxt = 1'b1;
            sat_nxt     = 1'b0;
            mode_nxt    = M_NSIGN;
          end else if (is_dg) begin
            mant_nxt    = md_m;
            frac_nxt    = md_fd;
            sat_nxt     = md_sat;
            expv_nxt    = '0;
            exp_neg_nxt = 1'b0;
            num_neg_nxt = 1'b0;
            mode_nxt    = M_NINT;
          end else if (is_al) begin
            kw_bytes_nxt[0] = c;
            kw_cnt_nxt      = CNT_W'(1);
            mode_nxt        = M_KW;
          end else if (!is_sp && !is_pu) begin
            mode_nxt = M_ERROR;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Results of the accepted word: a closing token first, then a new one
  // ---------------------------------------------------------------------
  logic      first_v, second_v;
  out_word_t first_w, second_w;
  out_word_t res_a, res_b;

  always_comb begin
    first_v  = 1'b0;
    second_v = 1'b0;
    first_w  = mk_word(K_PUNCT, 8'h00, E_UNEXPECTED);
    second_w = mk_word(K_PUNCT, 8'h00, E_UNEXPECTED);
    if (eoi) begin
      first_v = 1'b1;
      case (mode_r)
        M_KW:                               first_w = kw_word;
        M_NINT, M_NFRAC, M_NEXP:            first_w = num_word;
        M_NSIGN, M_NDOT, M_NE, M_NESIGN:    first_w = mk_word(K_ERROR, 8'h00, E_DIGIT);
        M_STR:                              first_w = mk_word(K_ERROR, 8'h00, E_NO_QUOTE);
        M_ESC:                              first_w = mk_word(K_ERROR, 8'h00, E_END_ESCAPE);
        default:                            first_v = 1'b0;
      endcase
      second_v = 1'b1;
      second_w = mk_word(K_END, 8'h00, E_UNEXPECTED);
    end else begin
      case (mode_r)
        M_STR: begin
          if (c == CH_QUOTE) begin
            first_v = 1'b1;
            first_w = mk_word(K_STR_END, 8'h00, E_UNEXPECTED);
          end else if (c != CH_BSLASH) begin
            first_v = 1'b1;
            first_w = mk_word(K_STR_BYTE, c, E_UNEXPECTED);
          end
        end
        M_ESC: begin
          first_v = 1'b1;
          first_w = mk_word(K_STR_BYTE, c, E_UNEXPECTED);
        end
        M_KW: begin
          first_v = kw_close;
          first_w = kw_word;
        end
        M_NSIGN, M_NDOT, M_NE, M_NESIGN: begin
          first_v = num_fail;
          first_w = mk_word(K_ERROR, 8'h00, E_DIGIT);
        end
        M_NINT, M_NFRAC, M_NEXP: begin
          first_v = num_close;
          first_w = num_word;
        end
        default: ;
      endcase
      if (start_go) begin
        if (is_pu) begin
          second_v = 1'b1;
          second_w = mk_word(K_PUNCT, c, E_UNEXPECTED);
        end else if (!is_sp && !is_al && !is_dg && (c != CH_QUOTE) && (c != CH_MINUS)) begin
          second_v = 1'b1;
          second_w = mk_word(K_ERROR, 8'h00, E_UNEXPECTED);
        end
      end
    end

    // pack into slots, flag the final one
    res_a = first_v ? first_w : second_w;
    res_b = second_w;
    if (first_v && second_v) res_b.last = 1'b1;
    else res_a.last = 1'b1;
  end

  // ---------------------------------------------------------------------
  // Output buffer update
  // ---------------------------------------------------------------------
  always_comb begin
    q0_nxt   = q0_r;
    q1_nxt   = q1_r;
    qcnt_nxt = qcnt_r;
    if (step) begin
      q0_nxt   = res_a;
      q1_nxt   = res_b;
      qcnt_nxt = {1'b0, first_v} + {1'b0, second_v};
    end else if (pop) begin
      q0_nxt   = q1_r;
      qcnt_nxt = qcnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      kw_cnt_r  <= '0;
      mant_r    <= '0;
      frac_r    <= '0;
      expv_r    <= '0;
      exp_neg_r <= 1'b0;
      num_neg_r <= 1'b0;
      sat_r     <= 1'b0;
      qcnt_r    <= 2'd0;
    end else begin
      mode_r    <= mode_nxt;
      kw_cnt_r  <= kw_cnt_nxt;
      mant_r    <= mant_nxt;
      frac_r    <= frac_nxt;
      expv_r    <= expv_nxt;
      exp_neg_r <= exp_neg_nxt;
      num_neg_r <= num_neg_nxt;
      sat_r     <= sat_nxt;
      qcnt_r    <= qcnt_nxt;
    end
  end

  // payload: keyword letters past the count are never compared
  always_ff @(posedge clk) begin
    kw_bytes_r <= kw_bytes_nxt;
    q0_r       <= q0_nxt;
    q1_r       <= q1_nxt;
  end

endmodule

/* rtl/core/jtok_checker.sv */
module jtok_checker
  import jtok_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // end token always closes its input word
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.kind == K_END) |-> out_word.last)
    else $error("end token without last flag");

  // numeric fields only on number tokens
  a_num_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.kind != K_NUMBER) |->
      (out_word.mantissa == '0) && (out_word.exponent == '0) &&
      !out_word.negative && !out_word.inexact)
    else $error("number fields set on non-number token");

  // an accepted end of input always has a result waiting next cycle
  a_eoi_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_word.action |=> out_valid)
    else $error("no result after end of input");

  // buffer empties on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind json_tokenizer jtok_checker u_jtok_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

/* test/tb.sv */
module tb;
  import jtok_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int CLK_PERIOD  = 2 * HALF_PERIOD;
  localparam int RESET_CYCLES = 9;
  localparam int KW_LEN    = 7;
  localparam int MANT_BITS = 60;
  localparam int RAND_WORDS = 800;      // input words sent before new random documents stop
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off
  localparam int MAX_REPORTS = 10;

  // Mantissa ceiling: all-ones at MANT_BITS or 18 nines, whichever is lower.
  localparam longint unsigned DEC_CAP   = 64'd999999999999999999;
  localparam longint unsigned MANT_FULL = (64'd1 << MANT_BITS) - 64'd1;
  localparam longint unsigned MANT_MAX  = (MANT_FULL < DEC_CAP) ? MANT_FULL : DEC_CAP;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  json_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Lexer shadow state, stepped once per accepted input word.
  // ---------------------------------------------------------------------------
  mode_t           lx_mode = M_IDLE;
  logic [7:0]      kw_buf [KW_LEN];
  int              kw_len = 0;
  longint unsigned num_mant = 0;
  int              num_frac = 0;     // dropped integer digits minus kept fraction digits
  int              num_exp = 0;      // written exponent magnitude, saturates at 4095
  bit              num_exp_neg = 0;
  bit              num_neg = 0;
  bit              num_sat = 0;

  out_word_t step_q[$];    // tokens produced by the current input word
  out_word_t token_q[$];   // tokens still owed by the block, oldest first

  function automatic out_word_t mk(kind_t k, logic [7:0] ch = 8'h00,
                                   err_t er = E_UNEXPECTED, logic lst = 1'b0);
    out_word_t w;
    w = '0;
    w.kind = k;
    w.char_value = ch;
    w.error_code = er;
    w.last = lst;
    return w;
  endfunction

  function automatic void put(out_word_t w);
    step_q.push_back(w);
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_punct(logic [7:0] c);
    return c == CH_COLON || c == CH_COMMA || c == CH_LBRACE || c == CH_RBRACE ||
           c == CH_LBRACK || c == CH_RBRACK;
  endfunction

  function automatic void clear_num();
    num_mant = 0;
    num_frac = 0;
    num_exp = 0;
    num_exp_neg = 0;
    num_neg = 0;
    num_sat = 0;
  endfunction

  function automatic void clear_kw();
    kw_len = 0;
    foreach (kw_buf[i]) kw_buf[i] = 8'h00;
  endfunction

  function automatic void lex_reset();
    lx_mode = M_IDLE;
    clear_kw();
    clear_num();
  endfunction

  function automatic void lex_fail(err_t code);
    put(mk(K_ERROR, 8'h00, code));
    lx_mode = M_ERROR;
  endfunction

  // Digit that no longer fits is dropped; before the point it still scales
  // the value, so the exponent moves up by one.
  function automatic void mant_add(logic [7:0] c, bit frac);
    longint unsigned d;
    d = 64'(c) - 64'h30;
    if (num_mant <= (MANT_MAX - d) / 64'd10) begin
      num_mant = num_mant * 64'd10 + d;
      if (frac) begin
        if (num_frac > -2048) num_frac--;
        else num_sat = 1;
      end
    end else begin
      if (d != 0) num_sat = 1;
      if (!frac) begin
        if (num_frac < 2047) num_frac++;
        else num_sat = 1;
      end
    end
  endfunction

  function automatic void exp_add(logic [7:0] c);
    int v;
    v = num_exp * 10 + int'(c - 8'h30);
    if (v > 4095) begin
      v = 4095;
      num_sat = 1;
    end
    num_exp = v;
  endfunction

  function automatic void emit_num();
    int e;
    bit inex;
    out_word_t w;
    e = num_exp_neg ? -num_exp : num_exp;
    e += num_frac;
    inex = num_sat;
    if (e > 2047) begin
      e = 2047;
      inex = 1;
    end
    if (e < -2048) begin
      e = -2048;
      inex = 1;
    end
    w = mk(K_NUMBER);
    w.negative = num_neg;
    w.mantissa = num_mant[MANT_OUT_W-1:0];
    w.exponent = e[EXP_W-1:0];
    w.inexact = inex;
    put(w);
    clear_num();
    lx_mode = M_IDLE;
  endfunction

  function automatic bit kw_match(string s);
    if (kw_len != s.len()) return 0;
    for (int i = 0; i < kw_len; i++)
      if (kw_buf[i] != s[i]) return 0;
    return 1;
  endfunction

  function automatic void emit_kw();
    if (kw_match("true")) begin
      put(mk(K_TRUE));
      lx_mode = M_IDLE;
    end else if (kw_match("false")) begin
      put(mk(K_FALSE));
      lx_mode = M_IDLE;
    end else if (kw_match("null")) begin
      put(mk(K_NULL));
      lx_mode = M_IDLE;
    end else begin
      lex_fail(E_KEYWORD);
    end
    clear_kw();
  endfunction

  function automatic void start_tok(logic [7:0] c);
    if (is_ws(c)) return;
    if (c == CH_QUOTE) begin
      lx_mode = M_STR;
      return;
    end
    if (is_punct(c)) begin
      put(mk(K_PUNCT, c));
      return;
    end
    if (c == CH_MINUS) begin
      clear_num();
      num_neg = 1;
      lx_mode = M_NSIGN;
      return;
    end
    if (is_dig(c)) begin
      clear_num();
      mant_add(c, 0);
      lx_mode = M_NINT;
      return;
    end
    if (is_alpha(c)) begin
      kw_len = 1;
      kw_buf[0] = c;
      lx_mode = M_KW;
      return;
    end
    lex_fail(E_UNEXPECTED);
  endfunction

  // One input word -> zero, one or two tokens in step_q, last one flagged.
  function automatic void lex_step(in_word_t w);
    logic [7:0] c;
    out_word_t tail;
    step_q.delete();
    c = w.text_byte;
    if (w.action) begin
      // end of input: flush whatever is pending, then close the document
      case (lx_mode)
        M_KW: emit_kw();
        M_NINT, M_NFRAC, M_NEXP: emit_num();
        M_NSIGN, M_NDOT, M_NE, M_NESIGN: lex_fail(E_DIGIT);
        M_STR: lex_fail(E_NO_QUOTE);
        M_ESC: lex_fail(E_END_ESCAPE);
        default: ;
      endcase
      put(mk(K_END));
      lex_reset();
    end else begin
      case (lx_mode)
        M_IDLE: start_tok(c);
        M_STR: begin
          if (c == CH_BSLASH) lx_mode = M_ESC;
          else if (c == CH_QUOTE) begin
            put(mk(K_STR_END));
            lx_mode = M_IDLE;
          end else put(mk(K_STR_BYTE, c));
        end
        M_ESC: begin
          put(mk(K_STR_BYTE, c));
          lx_mode = M_STR;
        end
        M_KW: begin
          if (is_alpha(c) && kw_len < KW_LEN) begin
            kw_buf[kw_len] = c;
            kw_len++;
          end else begin
            // keyword closes; the byte starts the next token unless it errored
            emit_kw();
            if (lx_mode == M_IDLE) start_tok(c);
          end
        end
        M_NSIGN: begin
          if (is_dig(c)) begin
            mant_add(c, 0);
            lx_mode = M_NINT;
          end else lex_fail(E_DIGIT);
        end
        M_NINT: begin
          if (is_dig(c)) mant_add(c, 0);
          else if (c == CH_DOT) lx_mode = M_NDOT;
          else if (c == CH_E_LO || c == CH_E_UP) lx_mode = M_NE;
          else begin
            emit_num();
            start_tok(c);
          end
        end
        M_NDOT: begin
          if (is_dig(c)) begin
            mant_add(c, 1);
            lx_mode = M_NFRAC;
          end else lex_fail(E_DIGIT);
        end
        M_NFRAC: begin
          if (is_dig(c)) mant_add(c, 1);
          else if (c == CH_E_LO || c == CH_E_UP) lx_mode = M_NE;
          else begin
            emit_num();
            start_tok(c);
          end
        end
        M_NE: begin
          if (c == CH_MINUS) begin
            num_exp_neg = 1;
            lx_mode = M_NESIGN;
          end else if (c == CH_PLUS) lx_mode = M_NESIGN;
          else if (is_dig(c)) begin
            exp_add(c);
            lx_mode = M_NEXP;
          end else lex_fail(E_DIGIT);
        end
        M_NESIGN: begin
          if (is_dig(c)) begin
            exp_add(c);
            lx_mode = M_NEXP;
          end else lex_fail(E_DIGIT);
        end
        M_NEXP: begin
          if (is_dig(c)) exp_add(c);
          else begin
            emit_num();
            start_tok(c);
          end
        end
        default: ;  // error mode swallows every byte
      endcase
    end
    if (step_q.size() > 0) begin
      tail = step_q.pop_back();
      tail.last = 1'b1;
      step_q.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table: a row either carries its tokens typed in (n_fixed >= 0)
  // or leaves them to the shadow lexer (n_fixed < 0).
  // ---------------------------------------------------------------------------
  typedef struct {
    in_word_t  w;
    int        n_fixed;
    out_word_t r0;
    out_word_t r1;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic void row_fixed(logic act, logic [7:0] b, int n,
                                    out_word_t r0, out_word_t r1);
    plan_row_t r;
    r.w = {act, b};
    r.n_fixed = n;
    r.r0 = r0;
    r.r1 = r1;
    plan.push_back(r);
  endfunction

  function automatic void row_text(string s);
    for (int i = 0; i < s.len(); i++) row_fixed(1'b0, s[i], -1, '0, '0);
  endfunction

  function automatic void build_plan();
    out_word_t fin;
    fin = mk(K_END, 8'h00, E_UNEXPECTED, 1'b1);
    row_fixed(1'b0, CH_LBRACE, 1, mk(K_PUNCT, CH_LBRACE, E_UNEXPECTED, 1'b1), '0);
    // string cut off inside an escape
    row_text("\"\\");
    row_fixed(1'b1, 8'hA5, 2, mk(K_ERROR, 8'h00, E_END_ESCAPE), fin);
    // string with extreme content bytes, never closed
    row_text("\"");
    row_fixed(1'b0, 8'h00, -1, '0, '0);
    row_fixed(1'b0, 8'hFF, -1, '0, '0);
    row_fixed(1'b1, 8'h00, 2, mk(K_ERROR, 8'h00, E_NO_QUOTE), fin);
    // keyword closed by punctuation in the same word
    row_text("null:");
    // unknown keyword flushed at end of input
    row_text("q");
    row_fixed(1'b1, 8'hFF, 2, mk(K_ERROR, 8'h00, E_KEYWORD), fin);
    row_text("-0.5E+7 ");
    // sign without digits, then a byte that is swallowed by the error
    row_text("-");
    row_fixed(1'b0, "x", 1, mk(K_ERROR, 8'h00, E_DIGIT, 1'b1), '0);
    row_text("#");
    row_fixed(1'b1, 8'h5A, 1, fin, '0);
    row_fixed(1'b0, "#", 1, mk(K_ERROR, 8'h00, E_UNEXPECTED, 1'b1), '0);
    row_fixed(1'b1, 8'h00, 1, fin, '0);
  endfunction

  // ---------------------------------------------------------------------------
  // Random documents: mostly well-formed JSON-ish text with random content,
  // sprinkled with stray bytes and truncated tokens.
  // ---------------------------------------------------------------------------
  in_word_t doc[$];

  function automatic void add_byte(logic [7:0] b);
    doc.push_back({1'b0, b});
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_digits(int n);
    repeat (n) add_byte(8'h30 + 8'($urandom_range(0, 9)));
  endfunction

  // Mostly short digit runs; sometimes long enough to overflow; rarely none.
  function automatic int digit_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 15) return $urandom_range(15, 24);
    return $urandom_range(1, 6);
  endfunction

  function automatic void gen_number();
    if ($urandom_range(0, 2) == 0) add_byte(CH_MINUS);
    add_digits(digit_count());
    if ($urandom_range(0, 99) < 35) begin
      add_byte(CH_DOT);
      add_digits(digit_count());
    end
    if ($urandom_range(0, 99) < 30) begin
      add_byte($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
      case ($urandom_range(0, 2))
        0: add_byte(CH_MINUS);
        1: add_byte(CH_PLUS);
        default: ;
      endcase
      // up to five digits pushes the exponent into its clamp
      add_digits(($urandom_range(0, 9) == 0) ? $urandom_range(4, 5) : digit_count() % 4);
    end
  endfunction

  function automatic void gen_string();
    logic [7:0] b;
    int tail;
    add_byte(CH_QUOTE);
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 99) < 15) begin
        add_byte(CH_BSLASH);
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_BSLASH) b = 8'h20;
        add_byte(b);
      end
    end
    tail = $urandom_range(0, 19);
    if (tail == 1) add_byte(CH_BSLASH);   // dangling escape
    else if (tail > 1) add_byte(CH_QUOTE);
  endfunction

  function automatic void gen_keyword();
    case ($urandom_range(0, 4))
      0: add_str("true");
      1: add_str("false");
      2: add_str("null");
      default: begin
        if ($urandom_range(0, 1)) add_str($urandom_range(0, 1) ? "true" : "null");
        else repeat ($urandom_range(1, 10))
          add_byte($urandom_range(0, 1) ? 8'h41 + 8'($urandom_range(0, 25))
                                        : 8'h61 + 8'($urandom_range(0, 25)));
      end
    endcase
  endfunction

  function automatic void gen_doc();
    int r;
    doc.delete();
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        case ($urandom_range(0, 5))
          0: add_byte(CH_COLON);
          1: add_byte(CH_COMMA);
          2: add_byte(CH_LBRACE);
          3: add_byte(CH_RBRACE);
          4: add_byte(CH_LBRACK);
          default: add_byte(CH_RBRACK);
        endcase
      end else if (r < 25) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 5))
            0: add_byte(8'h20);
            1: add_byte(8'h09);
            2: add_byte(8'h0A);
            3: add_byte(8'h0B);
            4: add_byte(8'h0C);
            default: add_byte(8'h0D);
          endcase
        end
      end else if (r < 45) gen_string();
      else if (r < 65) gen_keyword();
      else gen_number();
      if ($urandom_range(0, 1)) add_byte(8'h20);
      if ($urandom_range(0, 99) < 4) add_byte(8'($urandom_range(0, 255)));  // stray byte
    end
    doc.push_back({1'b1, 8'($urandom_range(0, 255))});
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of back-to-back words separated by random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int n_sent = 0;
  int n_end_words = 0;
  bit hold_req = 0;

  task automatic pace();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  // Present a word at the falling edge, hold it until accepted, then book
  // the tokens it owes. Returns at the next falling edge.
  task automatic send_word(in_word_t w, int n_fixed, out_word_t r0, out_word_t r1);
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    n_sent++;
    if (w.action) n_end_words++;
    lex_step(w);
    if (n_fixed < 0) begin
      foreach (step_q[i]) token_q.push_back(step_q[i]);
    end else if (n_fixed > 0) begin
      token_q.push_back(r0);
      if (n_fixed > 1) token_q.push_back(r1);
    end
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern changes from one random phase to the next; one long hold-off
  // once the random part is under way so the output buffer backs up.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int style;
    int phase_left;
    bit hold_done;
    style = 0;
    phase_left = 0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1;
      end
      if (phase_left == 0) begin
        style = $urandom_range(0, 3);
        phase_left = $urandom_range(5, 60);
      end
      phase_left--;
      case (style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every word taken from the block must match the oldest
  // token owed, field by field.
  // ---------------------------------------------------------------------------
  int n_fail = 0;
  int n_checked = 0;
  int n_numbers = 0;
  int n_inexact = 0;
  int n_errors = 0;
  int n_keywords = 0;

  function automatic string show(out_word_t w);
    return $sformatf("kind=%0d char=%02h neg=%0d mant=%0d exp=%0d inex=%0d err=%0d last=%0d",
                     w.kind, w.char_value, w.negative, w.mantissa, w.exponent,
                     w.inexact, w.error_code, w.last);
  endfunction

  function automatic void note_fail(string msg);
    n_fail++;
    if (n_fail <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  always @(posedge clk) begin : check_out
    out_word_t want;
    string bad;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (token_q.size() == 0) begin
        note_fail($sformatf("unexpected result word: %s", show(out_word)));
      end else begin
        want = token_q.pop_front();
        bad = "";
        if (out_word.kind !== want.kind) bad = {bad, " kind"};
        if (out_word.char_value !== want.char_value) bad = {bad, " char_value"};
        if (out_word.negative !== want.negative) bad = {bad, " negative"};
        if (out_word.mantissa !== want.mantissa) bad = {bad, " mantissa"};
        if (out_word.exponent !== want.exponent) bad = {bad, " exponent"};
        if (out_word.inexact !== want.inexact) bad = {bad, " inexact"};
        if (out_word.error_code !== want.error_code) bad = {bad, " error_code"};
        if (out_word.last !== want.last) bad = {bad, " last"};
        if (bad != "")
          note_fail($sformatf("result %0d mismatch in%s\n  want %s\n  got  %s",
                              n_checked, bad, show(want), show(out_word)));
        case (want.kind)
          K_NUMBER: begin
            n_numbers++;
            if (want.inexact) n_inexact++;
          end
          K_TRUE, K_FALSE, K_NULL: n_keywords++;
          K_ERROR: n_errors++;
          default: ;
        endcase
      end
      n_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    foreach (kw_buf[i]) kw_buf[i] = 8'h00;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    build_plan();
    foreach (plan[i]) begin
      pace();
      send_word(plan[i].w, plan[i].n_fixed, plan[i].r0, plan[i].r1);
    end

    while (n_sent < RAND_WORDS) begin
      gen_doc();
      foreach (doc[i]) begin
        pace();
        send_word(doc[i], -1, '0, '0);
      end
      if (n_sent > RAND_WORDS / 3) hold_req = 1;
    end

    // drain: wait for every owed token, then keep watching for stray results
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d words (%0d end-of-input), checked %0d tokens.",
             n_sent, n_end_words, n_checked);
    $display("Tokens seen: %0d numbers (%0d inexact), %0d keywords, %0d errors.",
             n_numbers, n_inexact, n_keywords, n_errors);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #(CLK_PERIOD * 400000);
    $display("Timeout with %0d tokens still owed", token_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
